// ===== hw/rtl/lbpg_pkg.sv =====
package lbpg_pkg;

  // Block geometry limits, in log2 bytes.
  localparam int MAX_SIZE_ORDER = 16;
  localparam int MIN_SIZE_ORDER = 9;
  // log2 of the word size in bytes.
  localparam int WORD_ORDER      = 3;
  localparam int ORDER_W         = 5;
  localparam int WORD_INDEX_W    = MAX_SIZE_ORDER - WORD_ORDER;

  // Configuration bus.
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 64;

  // Register indexes, taken from the 8-byte-aligned address.
  localparam logic REG_SALT       = 1'b0;
  localparam logic REG_SIZE_ORDER = 1'b1;

  // Linear congruential step: x * (2^32 + 15) + 17.
  localparam logic [63:0] LCG_ADD = 64'd17;

  // Function codes.
  localparam logic FUNC_GEN   = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] offset;
    logic [63:0] data_word;
  } item_t;

  typedef struct packed {
    logic [63:0] gen_word;
    logic        last_word;
    logic        block_bad;
    logic [63:0] first_offset;
  } result_t;

  typedef struct packed {
    logic [63:0]        salt;
    logic [ORDER_W-1:0] size_order;
  } cfg_t;

endpackage

// ===== hw/rtl/lbpg_cfg.sv =====
module lbpg_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [lbpg_pkg::DATA_W-1:0]   pwdata,
  output logic [lbpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lbpg_pkg::cfg_t                cfg
);

  logic                          wr_en;
  logic                          reg_sel;
  logic [63:0]                   salt;
  logic [lbpg_pkg::ORDER_W-1:0]  size_order;

  // Registers sit on 8-byte boundaries; bit 3 selects between them.
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      salt       <= 64'd0;
      size_order <= lbpg_pkg::ORDER_W'(lbpg_pkg::MIN_SIZE_ORDER);
    end else if (wr_en) begin
      unique case (reg_sel)
        lbpg_pkg::REG_SALT:       salt       <= pwdata;
        lbpg_pkg::REG_SIZE_ORDER: size_order <= pwdata[lbpg_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_sel)
      lbpg_pkg::REG_SALT:       prdata = salt;
      lbpg_pkg::REG_SIZE_ORDER: prdata = {{(lbpg_pkg::DATA_W - lbpg_pkg::ORDER_W){1'b0}},
                                          size_order};
      default:                  prdata = '0;
    endcase
  end

  assign cfg.salt       = salt;
  assign cfg.size_order = size_order;

endmodule

// ===== hw/rtl/lbpg_core.sv =====
module lbpg_core (
  input  logic              clk,
  input  logic              rst,
  input  lbpg_pkg::cfg_t    cfg,
  input  logic              accept,
  input  lbpg_pkg::item_t   item,
  output lbpg_pkg::result_t result_next
);

  logic [lbpg_pkg::WORD_INDEX_W-1:0] word_index;
  logic [63:0]                       sequence_value;
  logic                              mismatch_seen;
  logic [63:0]                       captured_offset;

  logic [lbpg_pkg::WORD_INDEX_W-1:0] word_index_next;
  logic [63:0]                       sequence_value_next;
  logic                              mismatch_seen_next;
  logic [63:0]                       captured_offset_next;

  logic [lbpg_pkg::ORDER_W-1:0]      order_eff;
  logic [lbpg_pkg::ORDER_W-1:0]      shamt;
  logic [lbpg_pkg::WORD_INDEX_W-1:0] last_index;
  logic                              first;
  logic                              last;
  logic [63:0]                       first_word;
  logic [63:0]                       lcg_step;
  logic [63:0]                       word;

  // Clamp the block order and derive the index of the last word.
  always_comb begin
    if (cfg.size_order < lbpg_pkg::ORDER_W'(lbpg_pkg::MIN_SIZE_ORDER)) begin
      order_eff = lbpg_pkg::ORDER_W'(lbpg_pkg::MIN_SIZE_ORDER);
    end else if (cfg.size_order > lbpg_pkg::ORDER_W'(lbpg_pkg::MAX_SIZE_ORDER)) begin
      order_eff = lbpg_pkg::ORDER_W'(lbpg_pkg::MAX_SIZE_ORDER);
    end else begin
      order_eff = cfg.size_order;
    end
    shamt      = lbpg_pkg::ORDER_W'(lbpg_pkg::MAX_SIZE_ORDER) - order_eff;
    last_index = {lbpg_pkg::WORD_INDEX_W{1'b1}} >> shamt;
  end

  // Multiply by 2^32 + 15 as shifts and adds: (x << 32) + (x << 4) - x.
  assign lcg_step = {sequence_value[31:0], 32'd0} + {sequence_value[59:0], 4'd0}
                  - sequence_value + lbpg_pkg::LCG_ADD;

  // Next state and result for the incoming word.
  always_comb begin
    first      = (word_index == '0);
    first_word = (item.func == lbpg_pkg::FUNC_CHECK) ? item.data_word : item.offset;
    last       = (word_index >= last_index);

    if (first) begin
      word                 = first_word;
      sequence_value_next  = first_word ^ cfg.salt;
      captured_offset_next = first_word;
      mismatch_seen_next   = 1'b0;
    end else begin
      word                 = lcg_step;
      sequence_value_next  = lcg_step;
      captured_offset_next = captured_offset;
      mismatch_seen_next   = mismatch_seen ||
                             ((item.func == lbpg_pkg::FUNC_CHECK) && (item.data_word != lcg_step));
    end

    word_index_next = last ? '0 : word_index + 1'b1;

    result_next.gen_word     = word;
    result_next.last_word    = last;
    result_next.block_bad    = mismatch_seen_next;
    result_next.first_offset = captured_offset_next;
  end

  // Block state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_index      <= '0;
      sequence_value  <= 64'd0;
      mismatch_seen   <= 1'b0;
      captured_offset <= 64'd0;
    end else if (accept) begin
      word_index      <= word_index_next;
      sequence_value  <= sequence_value_next;
      mismatch_seen   <= mismatch_seen_next;
      captured_offset <= captured_offset_next;
    end
  end

endmodule

// ===== hw/rtl/lbpg_skid.sv =====
module lbpg_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lbpg_pkg::result_t push_data,
  output logic              push_ready,
  output logic              result_valid,
  input  logic              result_ready,
  output lbpg_pkg::result_t result
);

  logic              out_valid;
  logic              skid_valid;
  lbpg_pkg::result_t out_data;
  lbpg_pkg::result_t skid_data;
  logic              pop;

  assign pop          = out_valid && result_ready;
  assign push_ready   = !skid_valid;
  assign result_valid = out_valid;
  assign result       = out_data;

  // Occupancy of the output register and the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload moves; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

// ===== hw/rtl/lcg_block_pattern_gen_check.sv =====
// Each result beat is formed combinationally from its item beat and registered
// in the output stage. Throughput: one item per cycle while item_ready is high,
// set by the sequence update (shift-and-add multiply by 2^32+15) in the core's
// state registers. A two-entry output stage takes one more item while a result
// is stalled, then holds item_ready low until the stalled result leaves.
// Reset (synchronous, active high) clears block state and output valids,
// and sets salt to 0 and block order to 9.
module lcg_block_pattern_gen_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lbpg_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output lbpg_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [lbpg_pkg::DATA_W-1:0]   pwdata,
  output logic [lbpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  lbpg_pkg::cfg_t    cfg;
  lbpg_pkg::result_t result_next;
  logic              accept;

  assign accept = item_valid && item_ready;

  // Configuration registers.
  lbpg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequence generation and checking.
  lbpg_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .item        (item),
    .result_next (result_next)
  );

  // Result register with skid entry.
  lbpg_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_data    (result_next),
    .push_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== dv/tb_lcg_block_pattern_gen_check.sv =====
`timescale 1ns / 100ps

module tb_lcg_block_pattern_gen_check;

  localparam logic [63:0] LCG_MUL     = 64'h0000_0001_0000_000F;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {STYLE_GEN, STYLE_CHECK, STYLE_MIXED} block_style_t;

  // Pattern scoreboard: tracks the block position, the running sequence and
  // the sticky bad flag, and holds the results still owed by the block.
  class lcg_scoreboard;
    logic [63:0]        salt;
    logic [4:0]         size_order;
    int unsigned        word_idx;
    logic [63:0]        seq_value;
    bit                 bad_seen;
    logic [63:0]        captured;
    lbpg_pkg::result_t  owed_q[$];
    int unsigned        errors;

    function new();
      salt       = '0;
      size_order = 5'(lbpg_pkg::MIN_SIZE_ORDER);
      word_idx   = 0;
      seq_value  = '0;
      bad_seen   = 1'b0;
      captured   = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic idx, logic [63:0] value);
      if (idx == lbpg_pkg::REG_SALT) begin
        salt = value;
      end else begin
        size_order = value[4:0];
      end
    endfunction

    // Words per block after clamping the order into the legal range.
    function int unsigned block_words();
      int unsigned ord;
      ord = size_order;
      if (ord < lbpg_pkg::MIN_SIZE_ORDER) ord = lbpg_pkg::MIN_SIZE_ORDER;
      if (ord > lbpg_pkg::MAX_SIZE_ORDER) ord = lbpg_pkg::MAX_SIZE_ORDER;
      return 1 << (ord - lbpg_pkg::WORD_ORDER);
    endfunction

    function bit at_block_start();
      return word_idx == 0;
    endfunction

    // Value the sequence takes on the next non-first word.
    function logic [63:0] next_word();
      logic [63:0] nxt;
      nxt = seq_value * LCG_MUL + lbpg_pkg::LCG_ADD;
      return nxt;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Advance the pattern state for one accepted beat and queue its result.
    function void note_item(lbpg_pkg::item_t it);
      logic [63:0]       first;
      lbpg_pkg::result_t want;
      bit                last;
      if (word_idx == 0) begin
        first     = (it.func == lbpg_pkg::FUNC_CHECK) ? it.data_word : it.offset;
        captured  = first;
        seq_value = first ^ salt;
        bad_seen  = 1'b0;
        want.gen_word = first;
      end else begin
        seq_value = next_word();
        want.gen_word = seq_value;
        if (it.func == lbpg_pkg::FUNC_CHECK && it.data_word != seq_value) bad_seen = 1'b1;
      end
      last = word_idx >= block_words() - 1;
      want.last_word    = last;
      want.block_bad    = bad_seen;
      want.first_offset = captured;
      owed_q.push_back(want);
      word_idx = last ? 0 : word_idx + 1;
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10) $display("%s: expected %h, got %h", what, want, got);
    endfunction

    function void check_result(lbpg_pkg::result_t got);
      lbpg_pkg::result_t want;
      if (owed_q.size() == 0) begin
        flag("result beat with none pending, gen_word", '0, got.gen_word);
        return;
      end
      want = owed_q.pop_front();
      if (want.gen_word !== got.gen_word) flag("gen_word", want.gen_word, got.gen_word);
      if (want.last_word !== got.last_word) flag("last_word", want.last_word, got.last_word);
      if (want.block_bad !== got.block_bad) flag("block_bad", want.block_bad, got.block_bad);
      if (want.first_offset !== got.first_offset) begin
        flag("first_offset", want.first_offset, got.first_offset);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          item_valid;
  logic                          item_ready;
  lbpg_pkg::item_t               item;
  logic                          result_valid;
  logic                          result_ready;
  lbpg_pkg::result_t             result;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lbpg_pkg::ADDR_W-1:0]   paddr;
  logic [lbpg_pkg::DATA_W-1:0]   pwdata;
  logic [lbpg_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  lcg_scoreboard sb = new();
  block_style_t  style = STYLE_GEN;
  int unsigned   corrupt_odds = 0;
  bit            idling = 1'b0;
  int unsigned   long_hold = 0;
  int unsigned   stall_left = 0;
  int unsigned   cycle_count = 0;

  lcg_block_pattern_gen_check dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next ready level.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) sb.check_result(result);
      if (long_hold > 0) begin
        long_hold--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Random 64-bit value, with the all-zero and all-one words mixed in.
  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic lbpg_pkg::item_t fixed_item(logic func, logic [63:0] offset,
                                                 logic [63:0] data);
    lbpg_pkg::item_t it;
    it.func      = func;
    it.offset    = offset;
    it.data_word = data;
    return it;
  endfunction

  // Build the next beat; a new block style is drawn at each block start.
  function automatic lbpg_pkg::item_t make_item();
    lbpg_pkg::item_t it;
    bit              start;
    start = sb.at_block_start();
    if (start) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: style = STYLE_GEN;
        9:          style = STYLE_MIXED;
        default:    style = STYLE_CHECK;
      endcase
      corrupt_odds = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 40) : 0;
    end
    it.func      = lbpg_pkg::FUNC_GEN;
    it.offset    = rand64();
    it.data_word = rand64();
    case (style)
      STYLE_CHECK: begin
        it.func = lbpg_pkg::FUNC_CHECK;
        if (!start) begin
          it.data_word = sb.next_word();
          if (corrupt_odds != 0 && $urandom_range(1, corrupt_odds) == 1) begin
            it.data_word ^= 64'd1 << $urandom_range(0, 63);
          end
        end
      end
      STYLE_MIXED: begin
        if ($urandom_range(0, 1) == 1) it.func = lbpg_pkg::FUNC_CHECK;
        if (!start && $urandom_range(0, 1) == 1) it.data_word = sb.next_word();
      end
      default: ;
    endcase
    return it;
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_item(lbpg_pkg::item_t it);
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  // Random sender gap; suppressed while the receiver is held off.
  task automatic gap();
    if (idling && long_hold == 0 && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic run_items(int unsigned n);
    repeat (n) begin
      gap();
      send_item(make_item());
    end
  endtask

  task automatic finish_block();
    while (!sb.at_block_start()) begin
      gap();
      send_item(make_item());
    end
  endtask

  // Stop offering and wait for every owed result.
  task automatic stop_items();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Setup and access phases, then the bus is released and left idle.
  task automatic apb_write(logic idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [63:0] salt, logic [4:0] order, int unsigned n);
    stop_items();
    apb_write(lbpg_pkg::REG_SALT, salt);
    apb_write(lbpg_pkg::REG_SIZE_ORDER, 64'(order));
    run_items(n);
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Generate block from a zero offset, then checks that pass and fail
    // inside it, and a generate word after the failure.
    send_item(fixed_item(lbpg_pkg::FUNC_GEN, '0, '1));
    send_item(fixed_item(lbpg_pkg::FUNC_GEN, '1, '1));
    send_item(fixed_item(lbpg_pkg::FUNC_CHECK, '0, sb.next_word()));
    send_item(fixed_item(lbpg_pkg::FUNC_CHECK, '0, ~sb.next_word()));
    send_item(fixed_item(lbpg_pkg::FUNC_GEN, '1, '0));
    send_item(fixed_item(lbpg_pkg::FUNC_CHECK, '1, sb.next_word()));

    // Order below the legal range mid-block; all-ones salt.
    stop_items();
    apb_write(lbpg_pkg::REG_SALT, '1);
    apb_write(lbpg_pkg::REG_SIZE_ORDER, 64'd8);
    finish_block();

    // Check block: the first word is taken as the block offset.
    send_item(fixed_item(lbpg_pkg::FUNC_CHECK, '0, '1));
    send_item(fixed_item(lbpg_pkg::FUNC_CHECK, '0, sb.next_word()));
    send_item(fixed_item(lbpg_pkg::FUNC_CHECK, '0,
                         sb.next_word() ^ 64'h8000_0000_0000_0000));
    send_item(fixed_item(lbpg_pkg::FUNC_GEN, '0, '0));
    finish_block();

    // Generate from an all-ones offset, seeding the sequence with zero.
    send_item(fixed_item(lbpg_pkg::FUNC_GEN, '1, '0));
    send_item(fixed_item(lbpg_pkg::FUNC_GEN, '0, '0));
    finish_block();

    // Random phases over several block sizes and salts.
    idling = 1'b1;
    run_phase(rand64(), 5'd9, 300);
    run_phase('0, 5'd0, 150);
    finish_block();
    run_phase(rand64(), 5'd12, 100);
    // Shrinking the block past the current position ends it at once.
    run_phase(rand64(), 5'd9, 100);

    // Hold off results long enough to back up the input side.
    stop_items();
    apb_write(lbpg_pkg::REG_SALT, '1);
    apb_write(lbpg_pkg::REG_SIZE_ORDER, 64'd31);
    long_hold = 200;
    run_items(200);

    run_phase(rand64(), 5'd10, 300);
    run_phase(rand64(), 5'd17, 100);
    run_phase(rand64(), 5'd16, 100);
    run_phase(rand64(), 5'd11, 100);

    // Final stretch at full rate on both sides.
    idling = 1'b0;
    run_phase(rand64(), 5'd9, 200);
    stop_items();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
